/* hw/rtl/btpc_pkg.sv */
package btpc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CAL_TEMP    = 8'd0;
    localparam t_cfg_idx CFG_CAL_PRESS_A = 8'd1;
    localparam t_cfg_idx CFG_CAL_PRESS_B = 8'd2;
    localparam t_cfg_idx CFG_CAL_PRESS_C = 8'd3;

    // Compensation constants
    localparam logic [32:0] TEMP_OFS   = 33'd128000;
    localparam logic [20:0] P_BASE     = 21'd1048576;
    localparam logic [63:0] NUM_SCALE  = 64'd3125;
    localparam logic [63:0] HALF_47    = 64'h0000_8000_0000_0000;
    localparam logic [35:0] TC_ROUND   = 36'd128;
    localparam logic signed [35:0] TC_MIN = -36'sd8388608;
    localparam logic signed [35:0] TC_MAX = 36'sd8388607;
    localparam int P5_SHIFT   = 17;
    localparam int P4_SHIFT   = 35;
    localparam int DEN_SHIFT  = 33;

    // Divider geometry: dividend is the full word, divisor is what the
    // 33-bit arithmetic shift leaves of a 64-bit product
    localparam int NUM_W     = 64;
    localparam int DIV_STEPS = NUM_W;
    localparam int DEN_W     = NUM_W - DEN_SHIFT;

    typedef struct packed {
        logic [31:0] fine_temp;
        logic [23:0] temp_centi;
    } t_side;

    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_div_req;

    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] quo;
        logic             nz;
        t_side            side;
    } t_div_rsp;

endpackage

/* hw/rtl/btpc_in_if.sv */
interface btpc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

/* hw/rtl/btpc_out_if.sv */
interface btpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] fine_temp;
    logic signed [23:0] temp_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;

    modport source (output valid, output fine_temp, output temp_centi,
                    output pressure_q24_8, output pressure_valid, input ready);
    modport sink   (input valid, input fine_temp, input temp_centi,
                    input pressure_q24_8, input pressure_valid, output ready);
endinterface

/* hw/rtl/btpc_div.sv */
module btpc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  btpc_pkg::t_div_req  i_req,
    output btpc_pkg::t_div_rsp  o_rsp
);
    localparam int Steps = btpc_pkg::DIV_STEPS;
    localparam int NumW  = btpc_pkg::NUM_W;
    localparam int DenW  = btpc_pkg::DEN_W;

    logic [Steps:0]        r_v;
    logic [NumW-1:0]       r_nq   [0:Steps];
    logic [DenW-1:0]       r_rem  [0:Steps-1];
    logic [DenW-1:0]       r_ud   [0:Steps-1];
    logic [Steps:0]        r_neg;
    logic [Steps:0]        r_nz;
    btpc_pkg::t_side       r_side [0:Steps];

    logic [NumW-1:0]       n_nq   [0:Steps-1];
    logic [DenW-1:0]       n_rem  [0:Steps-1];
    logic [DenW:0]         w_trial[0:Steps-1];

    logic                  r_out_v;
    logic [NumW-1:0]       r_quo;
    logic                  r_out_nz;
    btpc_pkg::t_side       r_out_side;

    logic [NumW-1:0]       w_un;
    logic [DenW-1:0]       w_ud;

    // Magnitudes of dividend and divisor
    assign w_un = i_req.num[NumW-1] ? ({NumW{1'b0}} - i_req.num) : i_req.num;
    assign w_ud = i_req.den[DenW-1] ? ({DenW{1'b0}} - i_req.den) : i_req.den;

    // One restoring step per stage, quotient bits shift into the dividend word
    always_comb begin
        for (int k = 0; k < Steps; k++) begin
            w_trial[k] = {r_rem[k], r_nq[k][NumW-1]};
            if (w_trial[k] >= {1'b0, r_ud[k]}) begin
                n_rem[k] = DenW'(w_trial[k] - {1'b0, r_ud[k]});
                n_nq[k]  = {r_nq[k][NumW-2:0], 1'b1};
            end else begin
                n_rem[k] = w_trial[k][DenW-1:0];
                n_nq[k]  = {r_nq[k][NumW-2:0], 1'b0};
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[Steps-1:0], i_req.valid};
            r_out_v <= r_v[Steps];
        end
    end

    // Data path
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nq[0]   <= w_un;
            r_rem[0]  <= '0;
            r_ud[0]   <= w_ud;
            r_neg[0]  <= i_req.num[NumW-1] ^ i_req.den[DenW-1];
            r_nz[0]   <= (i_req.den != '0);
            r_side[0] <= i_req.side;
            for (int k = 0; k < Steps; k++) begin
                r_nq[k+1]   <= n_nq[k];
                r_neg[k+1]  <= r_neg[k];
                r_nz[k+1]   <= r_nz[k];
                r_side[k+1] <= r_side[k];
            end
            for (int k = 0; k < Steps - 1; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_ud[k+1]  <= r_ud[k];
            end
            r_quo      <= r_neg[Steps] ? ({NumW{1'b0}} - r_nq[Steps]) : r_nq[Steps];
            r_out_nz   <= r_nz[Steps];
            r_out_side <= r_side[Steps];
        end
    end

    assign o_rsp.valid = r_out_v;
    assign o_rsp.quo   = r_quo;
    assign o_rsp.nz    = r_out_nz;
    assign o_rsp.side  = r_out_side;

endmodule

/* hw/rtl/baro_temp_pressure_compensation.sv */
// Stages: 11 front stages, 66 divider stages, 4 back stages, 1 output register.
// Throughput: one reading per cycle; the whole pipeline holds when the output
//   register is full and not taken. The 64-step divider sets the depth.
// Reset: synchronous active low; clears trim registers and all valid bits.
module baro_temp_pressure_compensation (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [63:0]                          i_cfg_wdata,
    btpc_in_if.sink                              i_in,
    btpc_out_if.source                           o_out
);

    // Trim registers
    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_press_a;
    logic [63:0] r_cal_press_b;
    logic [15:0] r_cal_press_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp    <= '0;
            r_cal_press_a <= '0;
            r_cal_press_b <= '0;
            r_cal_press_c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                btpc_pkg::CFG_CAL_TEMP:    r_cal_temp    <= i_cfg_wdata[47:0];
                btpc_pkg::CFG_CAL_PRESS_A: r_cal_press_a <= i_cfg_wdata;
                btpc_pkg::CFG_CAL_PRESS_B: r_cal_press_b <= i_cfg_wdata;
                btpc_pkg::CFG_CAL_PRESS_C: r_cal_press_c <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [15:0] w_t1, w_t2, w_t3;
    logic [15:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    assign w_t1 = r_cal_temp[15:0];
    assign w_t2 = r_cal_temp[31:16];
    assign w_t3 = r_cal_temp[47:32];
    assign w_p1 = r_cal_press_a[15:0];
    assign w_p2 = r_cal_press_a[31:16];
    assign w_p3 = r_cal_press_a[47:32];
    assign w_p4 = r_cal_press_a[63:48];
    assign w_p5 = r_cal_press_b[15:0];
    assign w_p6 = r_cal_press_b[31:16];
    assign w_p7 = r_cal_press_b[47:32];
    assign w_p8 = r_cal_press_b[63:48];
    assign w_p9 = r_cal_press_c;

    // Low 64 bits of a 64-bit word times a 17-bit signed word
    function automatic logic [63:0] mul_w17(input logic [63:0] x, input logic [16:0] k);
        logic signed [80:0] prod;
        prod = $signed(x) * $signed(k);
        return prod[63:0];
    endfunction

    // Pipeline control: everything advances together
    logic        w_adv;
    logic [11:1] r_fv;
    logic [4:1]  r_bv;
    logic        r_out_valid;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;

    btpc_pkg::t_div_req w_req;
    btpc_pkg::t_div_rsp w_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv        <= '0;
            r_bv        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_fv        <= {r_fv[10:1], i_in.valid};
            r_bv        <= {r_bv[3:1], w_rsp.valid};
            r_out_valid <= r_bv[4];
        end
    end

    // Front stage registers
    logic [31:0] r1_x1, r1_d;
    logic [19:0] r1_adc_p, r2_adc_p, r3_adc_p, r4_adc_p, r5_adc_p, r6_adc_p, r7_adc_p, r8_adc_p;
    logic [31:0] r2_m1, r2_dd;
    logic [31:0] r3_v1, r3_m2;
    logic [31:0] r4_tf;
    logic [32:0] r5_a, r6_a;
    btpc_pkg::t_side r5_side, r6_side, r7_side, r8_side, r9_side, r10_side, r11_side;
    logic [63:0] r6_aa, r7_aa;
    logic [48:0] r6_ap5, r7_ap5, r7_ap2, r8_ap2;
    logic [63:0] r7_b1, r8_b2, r8_c3;
    logic [63:0] r9_a2, r9_n0, r10_s2, r10_num, r11_m, r11_num;

    // Front stage combinational terms
    logic [31:0]        w_x1, w_d, w_q;
    logic [35:0]        w_tf36, w_t5, w_tcs;
    logic [23:0]        n_tc;
    logic signed [65:0] w_aa;
    logic signed [48:0] w_ap5, w_ap2;
    logic [20:0]        w_pb;

    assign w_x1 = {15'b0, i_in.raw_temperature[19:3]} - {15'b0, w_t1, 1'b0};
    assign w_d  = {16'b0, i_in.raw_temperature[19:4]} - {16'b0, w_t1};
    assign w_q  = {{12{r2_dd[31]}}, r2_dd[31:12]};

    // Centi-degree rounding and saturation
    assign w_tf36 = {{4{r4_tf[31]}}, r4_tf};
    assign w_t5   = (w_tf36 << 2) + w_tf36 + btpc_pkg::TC_ROUND;
    assign w_tcs  = {{8{w_t5[35]}}, w_t5[35:8]};
    always_comb begin
        if ($signed(w_tcs) < btpc_pkg::TC_MIN) begin
            n_tc = btpc_pkg::TC_MIN[23:0];
        end else if ($signed(w_tcs) > btpc_pkg::TC_MAX) begin
            n_tc = btpc_pkg::TC_MAX[23:0];
        end else begin
            n_tc = w_tcs[23:0];
        end
    end

    assign w_aa  = $signed(r5_a) * $signed(r5_a);
    assign w_ap5 = $signed(r5_a) * $signed(w_p5);
    assign w_ap2 = $signed(r6_a) * $signed(w_p2);
    assign w_pb  = btpc_pkg::P_BASE - {1'b0, r8_adc_p};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // fine temperature terms
            r1_x1    <= w_x1;
            r1_d     <= w_d;
            r1_adc_p <= i_in.raw_pressure;
            r2_m1    <= r1_x1 * {{16{w_t2[15]}}, w_t2};
            r2_dd    <= r1_d * r1_d;
            r2_adc_p <= r1_adc_p;
            r3_v1    <= {{11{r2_m1[31]}}, r2_m1[31:11]};
            r3_m2    <= w_q * {{16{w_t3[15]}}, w_t3};
            r3_adc_p <= r2_adc_p;
            r4_tf    <= r3_v1 + {{14{r3_m2[31]}}, r3_m2[31:14]};
            r4_adc_p <= r3_adc_p;
            // centi-degrees and pressure offset term
            r5_side.fine_temp  <= r4_tf;
            r5_side.temp_centi <= n_tc;
            r5_a     <= {r4_tf[31], r4_tf} - btpc_pkg::TEMP_OFS;
            r5_adc_p <= r4_adc_p;
            // squared offset and linear terms
            r6_aa    <= w_aa[63:0];
            r6_ap5   <= w_ap5;
            r6_a     <= r5_a;
            r6_side  <= r5_side;
            r6_adc_p <= r5_adc_p;
            r7_b1    <= mul_w17(r6_aa, {w_p6[15], w_p6});
            r7_ap2   <= w_ap2;
            r7_ap5   <= r6_ap5;
            r7_aa    <= r6_aa;
            r7_side  <= r6_side;
            r7_adc_p <= r6_adc_p;
            r8_c3    <= mul_w17(r7_aa, {w_p3[15], w_p3});
            r8_b2    <= r7_b1 + ({{15{r7_ap5[48]}}, r7_ap5} << btpc_pkg::P5_SHIFT)
                        + ({{48{w_p4[15]}}, w_p4} << btpc_pkg::P4_SHIFT);
            r8_ap2   <= r7_ap2;
            r8_side  <= r7_side;
            r8_adc_p <= r7_adc_p;
            // divisor path and dividend path
            r9_a2    <= {{8{r8_c3[63]}}, r8_c3[63:8]} + ({{15{r8_ap2[48]}}, r8_ap2} << 12);
            r9_n0    <= ({43'b0, w_pb} << 31) - r8_b2;
            r9_side  <= r8_side;
            r10_s2   <= btpc_pkg::HALF_47 + r9_a2;
            r10_num  <= r9_n0 * btpc_pkg::NUM_SCALE;
            r10_side <= r9_side;
            r11_m    <= mul_w17(r10_s2, {1'b0, w_p1});
            r11_num  <= r10_num;
            r11_side <= r10_side;
        end
    end

    assign w_req.valid = r_fv[11];
    assign w_req.num   = r11_num;
    assign w_req.den   = r11_m[63:btpc_pkg::DEN_SHIFT];
    assign w_req.side  = r11_side;

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Back stage registers
    logic [63:0] r_t1_q, r_t1_s, r_t1_ps, r_t1_e;
    logic [39:0] r_t2_q, r_t2_e, r_t3_q, r_t3_e;
    logic [63:0] r_t2_ll, r_t3_pss;
    logic [31:0] r_t2_lh, r_t2_hl;
    logic [39:0] r_t4_sum;
    logic        r_t1_nz, r_t2_nz, r_t3_nz, r_t4_nz;
    btpc_pkg::t_side r_t1_side, r_t2_side, r_t3_side, r_t4_side, r_out_side;
    logic [31:0] r_out_p;
    logic        r_out_pv;
    logic [63:0] w_s;

    assign w_s = {{13{w_rsp.quo[63]}}, w_rsp.quo[63:13]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // second-order and first-order corrections
            r_t1_q    <= w_rsp.quo;
            r_t1_s    <= w_s;
            r_t1_ps   <= mul_w17(w_s, {w_p9[15], w_p9});
            r_t1_e    <= mul_w17(w_rsp.quo, {w_p8[15], w_p8});
            r_t1_nz   <= w_rsp.nz;
            r_t1_side <= w_rsp.side;
            // low 64 bits of the wide square product, as partial products
            r_t2_ll   <= {32'b0, r_t1_ps[31:0]} * {32'b0, r_t1_s[31:0]};
            r_t2_lh   <= r_t1_ps[31:0] * r_t1_s[63:32];
            r_t2_hl   <= r_t1_ps[63:32] * r_t1_s[31:0];
            r_t2_q    <= r_t1_q[39:0];
            // low 40 bits of the first-order term after its 19-bit shift
            r_t2_e    <= r_t1_e[58:19];
            r_t2_nz   <= r_t1_nz;
            r_t2_side <= r_t1_side;
            r_t3_pss  <= r_t2_ll + {r_t2_lh + r_t2_hl, 32'b0};
            r_t3_q    <= r_t2_q;
            r_t3_e    <= r_t2_e;
            r_t3_nz   <= r_t2_nz;
            r_t3_side <= r_t2_side;
            // only bits 39:8 of the corrected sum reach the output
            r_t4_sum  <= r_t3_q + {r_t3_pss[63], r_t3_pss[63:25]} + r_t3_e;
            r_t4_nz   <= r_t3_nz;
            r_t4_side <= r_t3_side;
            r_out_p   <= r_t4_nz ? (r_t4_sum[39:8] + {{12{w_p7[15]}}, w_p7, 4'b0}) : '0;
            r_out_pv  <= r_t4_nz;
            r_out_side <= r_t4_side;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.fine_temp      = $signed(r_out_side.fine_temp);
    assign o_out.temp_centi     = $signed(r_out_side.temp_centi);
    assign o_out.pressure_q24_8 = r_out_p;
    assign o_out.pressure_valid = r_out_pv;

    // Checks
    a_zero_div_zero_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.pressure_valid |-> o_out.pressure_q24_8 == '0)
        else $error("pressure nonzero with zero divisor");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_fv) && $stable(r_bv) && $stable(r_out_valid))
        else $error("pipeline moved during stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_fv == '0 && r_bv == '0 && !r_out_valid)
        else $error("valid bits not cleared by reset");

endmodule

/* test/baro_comp_scoreboard.sv */
// Predicts compensated readings and checks the block's results in order.
class baro_comp_scoreboard;

    typedef struct {
        logic [31:0] fine_temp;
        logic [23:0] temp_centi;
        logic [31:0] pressure_q24_8;
        logic        pressure_valid;
    } t_reading;

    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [15:0] cal_press_c;
    t_reading    pending[$];
    int          errors;

    function new();
        cal_temp    = '0;
        cal_press_a = '0;
        cal_press_b = '0;
        cal_press_c = '0;
        errors      = 0;
    endfunction

    function void write_trim(logic [7:0] idx, logic [63:0] value);
        case (idx)
            btpc_pkg::CFG_CAL_TEMP:    cal_temp    = value[47:0];
            btpc_pkg::CFG_CAL_PRESS_A: cal_press_a = value;
            btpc_pkg::CFG_CAL_PRESS_B: cal_press_b = value;
            btpc_pkg::CFG_CAL_PRESS_C: cal_press_c = value[15:0];
            default: ;
        endcase
    endfunction

    // Signed trim word k of a packed register
    function automatic logic signed [63:0] trim16(logic [63:0] r, int k);
        logic [15:0] w;
        w = r[16*k +: 16];
        return 64'(signed'(w));
    endfunction

    function automatic logic signed [63:0] sdiv(logic signed [63:0] n,
                                                logic signed [63:0] d);
        logic [63:0] un, ud, q;
        un = n[63] ? -n : n;
        ud = d[63] ? -d : d;
        q  = un / ud;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function void note_reading(logic [19:0] adc_p, logic [19:0] adc_t);
        t_reading r;
        logic signed [31:0] t1, t2, t3, v1, v2, dt, tf;
        logic signed [63:0] tf64, tc, a, b, p, s, c, e;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        // fine temperature, 32-bit wrapping
        t1 = {16'd0, cal_temp[15:0]};
        t2 = 32'(trim16({16'd0, cal_temp}, 1));
        t3 = 32'(trim16({16'd0, cal_temp}, 2));
        v1 = ($signed(32'({12'd0, adc_t} >> 3)) - (t1 << 1)) * t2 >>> 11;
        dt = 32'({12'd0, adc_t} >> 4) - t1;
        v2 = ((dt * dt) >>> 12) * t3 >>> 14;
        tf = v1 + v2;
        tf64 = 64'(tf);
        // centi-degrees, saturated
        tc = (tf64 * 5 + 128) >>> 8;
        if (tc < -64'sd8388608) tc = -64'sd8388608;
        if (tc > 64'sd8388607) tc = 64'sd8388607;
        // pressure, 64-bit wrapping
        p1 = {48'd0, cal_press_a[15:0]};
        p2 = trim16(cal_press_a, 1);
        p3 = trim16(cal_press_a, 2);
        p4 = trim16(cal_press_a, 3);
        p5 = trim16(cal_press_b, 0);
        p6 = trim16(cal_press_b, 1);
        p7 = trim16(cal_press_b, 2);
        p8 = trim16(cal_press_b, 3);
        p9 = trim16({48'd0, cal_press_c}, 0);
        a = tf64 - 128000;
        b = a * a * p6 + ((a * p5) << 17) + (p4 << 35);
        a = ((a * a * p3) >>> 8) + ((a * p2) << 12);
        a = ((64'sh0000_8000_0000_0000 + a) * p1) >>> 33;
        r.fine_temp  = tf;
        r.temp_centi = tc[23:0];
        if (a != 0) begin
            p = 64'sd1048576 - 64'(adc_p);
            p = sdiv(((p << 31) - b) * 3125, a);
            s = p >>> 13;
            c = (p9 * s * s) >>> 25;
            e = (p8 * p) >>> 19;
            p = ((p + c + e) >>> 8) + (p7 << 4);
            r.pressure_q24_8 = p[31:0];
            r.pressure_valid = 1'b1;
        end else begin
            r.pressure_q24_8 = '0;
            r.pressure_valid = 1'b0;
        end
        pending.push_back(r);
    endfunction

    function void check_reading(logic [31:0] ft, logic [23:0] tc, logic [31:0] pq,
                                logic pv);
        t_reading x;
        if (pending.size() == 0) begin
            $error("unexpected result: fine_temp %0h", ft);
            errors++;
            return;
        end
        x = pending.pop_front();
        if (ft !== x.fine_temp) begin
            $error("fine_temp: expected %0h, got %0h", x.fine_temp, ft);
            errors++;
        end
        if (tc !== x.temp_centi) begin
            $error("temp_centi: expected %0h, got %0h", x.temp_centi, tc);
            errors++;
        end
        if (pq !== x.pressure_q24_8) begin
            $error("pressure_q24_8: expected %0h, got %0h", x.pressure_q24_8, pq);
            errors++;
        end
        if (pv !== x.pressure_valid) begin
            $error("pressure_valid: expected %0b, got %0b", x.pressure_valid, pv);
            errors++;
        end
    endfunction

endclass

/* test/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 82;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    btpc_pkg::t_cfg_idx    i_cfg_idx = '0;
    logic [63:0]           i_cfg_wdata = '0;

    btpc_in_if  in_ch();
    btpc_out_if out_ch();

    baro_comp_scoreboard readings = new();
    bit stall_on;

    baro_temp_pressure_compensation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.raw_pressure = '0;
        in_ch.raw_temperature = '0;
        out_ch.ready = 1'b0;
    end

    // Receiver: stall pattern changes in phases; some phases never stall
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            readings.check_reading(out_ch.fine_temp, out_ch.temp_centi,
                                   out_ch.pressure_q24_8, out_ch.pressure_valid);
        if ($urandom_range(0, 63) == 0) stall_on <= ($urandom_range(0, 2) != 0);
        out_ch.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // One register write; the write port is idle again before the task returns
    task automatic write_trim(btpc_pkg::t_cfg_idx idx, logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        readings.write_trim(idx, value);
        @(posedge i_clk);
    endtask

    // Present one reading and hold it until the transfer
    task automatic send_reading(logic [19:0] adc_p, logic [19:0] adc_t, bit keep);
        in_ch.valid           <= 1'b1;
        in_ch.raw_pressure    <= adc_p;
        in_ch.raw_temperature <= adc_t;
        do @(posedge i_clk); while (!in_ch.ready);
        readings.note_reading(adc_p, adc_t);
        if (!keep) in_ch.valid <= 1'b0;
    endtask

    task automatic send_burst(int n);
        int burst;
        int gap;
        while (n > 0) begin
            burst = $urandom_range(1, 24);
            gap   = $urandom_range(0, 6);
            for (int k = 0; k < burst && n > 0; k++, n--)
                send_reading($urandom_range(0, 20'hFFFFF),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                         : $urandom_range(400000, 600000),
                             (k < burst - 1 || gap == 0) && n > 1);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (readings.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Typical datasheet-like trim set
    task automatic typical_trims();
        write_trim(btpc_pkg::CFG_CAL_TEMP, {16'hFC18, 16'd26435, 16'd27504});
        write_trim(btpc_pkg::CFG_CAL_PRESS_A, {16'd2855, 16'h2710, 16'hD6D0, 16'd36477});
        write_trim(btpc_pkg::CFG_CAL_PRESS_B, {16'd3024, 16'hFFF9, 16'hFFF9, 16'd140});
        write_trim(btpc_pkg::CFG_CAL_PRESS_C, 64'd6000);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // After reset P1 is zero: pressure never valid
        send_reading(20'h00000, 20'h00000, 1);
        send_reading(20'hFFFFF, 20'hFFFFF, 0);
        drain();
        typical_trims();
        send_reading(20'd415148, 20'd519888, 1);
        send_reading(20'h00000, 20'h00000, 1);
        send_reading(20'hFFFFF, 20'hFFFFF, 1);
        send_reading(20'h00000, 20'hFFFFF, 1);
        send_reading(20'hFFFFF, 20'h00000, 1);
        send_reading(20'h55555, 20'hAAAAA, 1);
        send_reading(20'hAAAAA, 20'h55555, 0);
        drain();
        // Extreme trims: all ones with P9 most negative, then mainly most negative / most positive words
        write_trim(btpc_pkg::CFG_CAL_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(btpc_pkg::CFG_CAL_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(btpc_pkg::CFG_CAL_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(btpc_pkg::CFG_CAL_PRESS_C, 64'h0000_0000_0000_8000);
        send_reading(20'h00000, 20'hFFFFF, 1);
        send_reading(20'hFFFFF, 20'h00000, 1);
        send_burst(6);
        drain();
        write_trim(btpc_pkg::CFG_CAL_TEMP, {16'h7FFF, 16'h7FFF, 16'h0000});
        write_trim(btpc_pkg::CFG_CAL_PRESS_A, {16'h8000, 16'h8000, 16'h7FFF, 16'h0001});
        write_trim(btpc_pkg::CFG_CAL_PRESS_B, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        write_trim(btpc_pkg::CFG_CAL_PRESS_C, 64'h7FFF);
        send_reading(20'h00000, 20'h00000, 1);
        send_reading(20'hFFFFF, 20'hFFFFF, 1);
        send_burst(6);
        drain();
        // Random phases: every third uses realistic trims, the rest are fully random
        for (int ph = 0; ph < 12; ph++) begin
            if (ph % 3 == 0) begin
                typical_trims();
            end else begin
                write_trim(btpc_pkg::CFG_CAL_TEMP, {$urandom, $urandom});
                write_trim(btpc_pkg::CFG_CAL_PRESS_A, {$urandom, $urandom});
                write_trim(btpc_pkg::CFG_CAL_PRESS_B, {$urandom, $urandom});
                write_trim(btpc_pkg::CFG_CAL_PRESS_C, {$urandom, $urandom});
            end
            send_burst(150);
            drain();
        end
        if (readings.errors == 0)
            $display("baro_temp_pressure_compensation test passed");
        else
            $display("baro_temp_pressure_compensation test failed");
        $finish;
    end

    initial begin
        #4ms;
        $display("baro_temp_pressure_compensation test failed");
        $finish;
    end

endmodule
